// ===== rtl/lbcd_pkg.sv =====
// Package for the LRU block cache directory: request and status codes, sizes.
// No dependencies.
package lbcd_pkg;
	localparam int unsigned ENTRIES_DEF = 32;
	localparam int unsigned RESULT_LIMIT = 32;
	localparam logic [15:0] REF_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		KIND_GET = 3'd0,
		KIND_RELEASE = 3'd1,
		KIND_DIRTY = 3'd2,
		KIND_SYNC = 3'd3,
		KIND_INVAL = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_HIT = 2'd0,
		ST_MISS = 2'd1,
		ST_WB = 2'd2,
		ST_DONE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_OUT
	} state_t;

	// command broadcast to every cell at once
	typedef struct packed {
		logic       hit_upd;   // hit on matching cell
		logic       fill;      // refill the victim cell
		logic       rel;       // release on slot
		logic       mark;      // mark dirty on slot
		logic       wb_clr;    // clear dirty on the flush cursor cell
		logic       inv_clr;   // clear valid on the flush cursor cell
		logic [7:0]  dev;
		logic [31:0] blk;
	} cell_cmd_t;
endpackage

// ===== rtl/lru_block_cache_directory_top.sv =====
// LRU block cache directory: a row of entry cells and a request sequencer.
// Get, release and mark dirty: the request is registered at the accepting
// edge, the result is registered once the output register is free, and the
// sequencer then returns to idle for the next item. Sync and invalidate walk
// one entry per cycle while the output register is free. One item at a time.
// Reset (arst_n, async) clears all entries and counters, ranks entry i as i.
// Depends on lbcd_pkg and lbcd_cell.
module lru_block_cache_directory_top #(
	parameter int unsigned ENTRIES = lbcd_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  device_tag,
	input  logic [31:0] block_number,
	input  logic [4:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [4:0]  entry_index,
	output logic        writeback,
	output logic [7:0]  writeback_device,
	output logic [31:0] writeback_block,
	output logic [15:0] references,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic        last
);
	import lbcd_pkg::*;

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	state_t state_q, state_d;
	logic [2:0]  kind_q;
	logic [7:0]  dev_q;
	logic [31:0] blk_q;
	logic [4:0]  slot_q;
	logic [CW-1:0] cur_q;
	logic [5:0]  nres_q;
	logic [31:0] hits_q, misses_q, hits_d, misses_d;

	logic [ENTRIES-1:0] c_match, c_valid, c_dirty, c_sel;
	logic [7:0]  c_dev [ENTRIES];
	logic [31:0] c_blk [ENTRIES];
	logic [15:0] c_refs [ENTRIES];
	logic [IW-1:0] c_rank [ENTRIES];

	cell_cmd_t cmd;
	logic promote;
	logic [IW-1:0] sel_idx, sel_rank, hit_idx, lru_idx;
	logic any_hit, slot_ok;

	logic [IW-1:0] cur_i;
	logic cur_end, cand, at_lim, scan_stop, cur_hit, cur_inv, more_ahead;

	// output register
	logic        ov_q;
	logic [1:0]  st_q;
	logic [4:0]  ei_q;
	logic        wb_q;
	logic [7:0]  wd_q;
	logic [31:0] wbk_q, ht_q, mt_q;
	logic [15:0] rf_q;
	logic        last_q;
	logic        emit;
	logic [1:0]  e_st;
	logic [4:0]  e_ei;
	logic        e_wb, e_last;
	logic [7:0]  e_wd;
	logic [31:0] e_wbk;
	logic [15:0] e_rf;
	logic        oreg_free;

	assign oreg_free = !ov_q || !out_stall;
	assign in_stall = state_q != S_IDLE;

	genvar g;
	for (g = 0; g < ENTRIES; g++) begin : g_cell
		lbcd_cell #(.IW(IW)) u_cell (
			.clk, .arst_n,
			.rank_init(IW'(g)),
			.cmd, .sel(c_sel[g]), .sel_rank, .promote,
			.top_rank(IW'(ENTRIES - 1)),
			.match(c_match[g]), .valid(c_valid[g]), .dirty(c_dirty[g]),
			.dev(c_dev[g]), .blk(c_blk[g]), .refs(c_refs[g]), .rank(c_rank[g])
		);
	end

	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		lru_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (c_match[i] && !any_hit) begin
				any_hit = 1'b1;
				hit_idx = IW'(i);
			end
			if (c_rank[i] == '0) lru_idx = IW'(i);
		end
	end

	assign slot_ok = 32'(slot_q) < ENTRIES;
	assign cur_i = cur_q[IW-1:0];
	assign cur_end = cur_q == CW'(ENTRIES);
	assign cand = !cur_end && c_valid[cur_i] && c_dirty[cur_i]
		&& (kind_q == KIND_SYNC || c_dev[cur_i] == dev_q);
	assign at_lim = nres_q == 6'(RESULT_LIMIT);
	// a dirty entry beyond the result limit ends the walk, leaving the rest as is
	assign scan_stop = cur_end || (cand && at_lim);
	assign cur_hit = cand && !at_lim;
	assign cur_inv = !scan_stop && kind_q == KIND_INVAL && c_valid[cur_i]
		&& c_dev[cur_i] == dev_q;

	// any write-back still to come further along the row
	always_comb begin
		more_ahead = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (CW'(i) > cur_q && c_valid[i] && c_dirty[i]
				&& (kind_q == KIND_SYNC || c_dev[i] == dev_q)) more_ahead = 1'b1;
		end
	end

	always_comb begin
		unique case (state_q)
			S_IDLE: state_d = in_valid ? S_LOOK : S_IDLE;
			S_LOOK: begin
				if (!oreg_free) state_d = S_LOOK;
				else if (kind_q == KIND_SYNC || kind_q == KIND_INVAL) state_d = S_SCAN;
				else state_d = S_IDLE;
			end
			S_SCAN: state_d = (oreg_free && scan_stop) ? S_IDLE : S_SCAN;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.dev = dev_q;
		cmd.blk = blk_q;
		sel_idx = '0;
		promote = 1'b0;
		emit = 1'b0;
		hits_d = hits_q;
		misses_d = misses_q;
		e_st = ST_DONE; e_ei = '0; e_wb = 1'b0; e_wd = '0; e_wbk = '0;
		e_rf = '0; e_last = 1'b1;
		unique case (state_q)
			S_LOOK: if (oreg_free) begin
				case (kind_q) inside
					KIND_GET: begin
						emit = 1'b1;
						promote = 1'b1;
						if (any_hit) begin
							hits_d = hits_q + 32'd1;
							sel_idx = hit_idx;
							cmd.hit_upd = 1'b1;
							e_st = ST_HIT;
							e_ei = 5'(hit_idx);
							e_rf = (c_refs[hit_idx] == REF_MAX) ? REF_MAX
								: c_refs[hit_idx] + 16'd1;
						end else begin
							misses_d = misses_q + 32'd1;
							sel_idx = lru_idx;
							cmd.fill = 1'b1;
							e_st = ST_MISS;
							e_ei = 5'(lru_idx);
							e_rf = 16'd1;
							e_wb = c_valid[lru_idx] && c_dirty[lru_idx];
							e_wd = e_wb ? c_dev[lru_idx] : '0;
							e_wbk = e_wb ? c_blk[lru_idx] : '0;
						end
					end
					KIND_RELEASE, KIND_DIRTY: begin
						emit = 1'b1;
						e_ei = slot_q;
						if (slot_ok) begin
							sel_idx = IW'(slot_q);
							cmd.rel = kind_q == KIND_RELEASE;
							cmd.mark = kind_q == KIND_DIRTY;
							e_rf = (kind_q == KIND_RELEASE && c_refs[sel_idx] != '0)
								? c_refs[sel_idx] - 16'd1 : c_refs[sel_idx];
						end
					end
					KIND_SYNC, KIND_INVAL: ;
					default: emit = 1'b1;
				endcase
			end
			S_SCAN: if (oreg_free) begin
				sel_idx = cur_i;
				if (scan_stop) begin
					emit = nres_q == '0;
				end else begin
					cmd.wb_clr = cur_hit;
					cmd.inv_clr = cur_inv;
					if (cur_hit) begin
						emit = 1'b1;
						e_st = ST_WB; e_ei = 5'(cur_i); e_wb = 1'b1;
						e_wd = c_dev[cur_i]; e_wbk = c_blk[cur_i]; e_rf = c_refs[cur_i];
						e_last = !more_ahead || (nres_q + 6'd1 == 6'(RESULT_LIMIT));
					end
				end
			end
			default: ;
		endcase
		sel_rank = c_rank[sel_idx];
	end

	always_comb begin
		c_sel = '0;
		c_sel[sel_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hits_q <= '0;
			misses_q <= '0;
			cur_q <= '0;
			nres_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hits_q <= hits_d;
			misses_q <= misses_d;
			if (state_q == S_IDLE && in_valid) begin
				cur_q <= '0;
				nres_q <= '0;
			end
			if (state_q == S_SCAN && oreg_free && !scan_stop) begin
				cur_q <= cur_q + CW'(1);
				if (cur_hit) nres_q <= nres_q + 6'd1;
			end
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			kind_q <= kind;
			dev_q <= device_tag;
			blk_q <= block_number;
			slot_q <= slot;
		end
		if (emit) begin
			st_q <= e_st; ei_q <= e_ei; wb_q <= e_wb; wd_q <= e_wd;
			wbk_q <= e_wbk; rf_q <= e_rf; last_q <= e_last;
			ht_q <= hits_d; mt_q <= misses_d;
		end
	end

	assign out_valid = ov_q;
	assign status = st_q;
	assign entry_index = ei_q;
	assign writeback = wb_q;
	assign writeback_device = wd_q;
	assign writeback_block = wbk_q;
	assign references = rf_q;
	assign hit_total = ht_q;
	assign miss_total = mt_q;
	assign last = last_q;
endmodule

// ===== rtl/lbcd_cell.sv =====
// One directory entry: tags, valid, dirty, count and recency rank.
// Depends on lbcd_pkg.
module lbcd_cell #(
	parameter int unsigned IW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IW-1:0]       rank_init,
	input  lbcd_pkg::cell_cmd_t cmd,
	input  logic                sel,        // this cell is the addressed one
	input  logic [IW-1:0]       sel_rank,   // rank of the cell moved to most recent
	input  logic                promote,    // a move to most recent happens
	input  logic [IW-1:0]       top_rank,
	output logic                match,
	output logic                valid,
	output logic                dirty,
	output logic [7:0]          dev,
	output logic [31:0]         blk,
	output logic [15:0]         refs,
	output logic [IW-1:0]       rank
);
	import lbcd_pkg::*;

	logic [7:0]    dev_q;
	logic [31:0]   blk_q;
	logic          valid_q, dirty_q;
	logic [15:0]   refs_q;
	logic [IW-1:0] rank_q;

	assign match = valid_q && dev_q == cmd.dev && blk_q == cmd.blk;
	assign valid = valid_q;
	assign dirty = dirty_q;
	assign dev = dev_q;
	assign blk = blk_q;
	assign refs = refs_q;
	assign rank = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= '0;
			blk_q <= '0;
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			refs_q <= '0;
			rank_q <= rank_init;
		end else begin
			if (promote) begin
				if (sel) rank_q <= top_rank;
				else if (rank_q > sel_rank) rank_q <= rank_q - 1'b1;
			end
			if (sel) begin
				if (cmd.hit_upd && refs_q != REF_MAX) refs_q <= refs_q + 16'd1;
				if (cmd.fill) begin
					dev_q <= cmd.dev;
					blk_q <= cmd.blk;
					valid_q <= 1'b1;
					dirty_q <= 1'b0;
					refs_q <= 16'd1;
				end
				if (cmd.rel && refs_q != '0) refs_q <= refs_q - 16'd1;
				if (cmd.mark && valid_q) dirty_q <= 1'b1;
				if (cmd.wb_clr || cmd.inv_clr) dirty_q <= 1'b0;
				if (cmd.inv_clr) valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/lbcd_checker.sv =====
// Port-level checks for the cache directory top level.
// Depends on lbcd_pkg; bound into lru_block_cache_directory_top below.
module lbcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        writeback,
	input logic [31:0] hit_total,
	input logic        last
);
	import lbcd_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled input item withdrawn");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled item changed");
	a_wb_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_HIT |-> !writeback)
		else $error("hit with write-back");
	a_wb_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DONE |-> last)
		else $error("done not last");
	a_hits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_HIT |-> hit_total != '0)
		else $error("hit count zero on hit");
endmodule

bind lru_block_cache_directory_top lbcd_checker u_lbcd_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .status,
	.writeback, .hit_total, .last
);
